@@ hdl/plcc_pkg.sv @@
// Shared types and constants for the pointer-layout compatibility checker.
// No dependencies.
`default_nettype none
package plcc_pkg;

  localparam int unsigned MAP_W      = 64;
  localparam int unsigned MAX_FIELDS = 63;
  // Field counts and slot indexes below the sentinel.
  localparam int unsigned CNT_W      = $clog2(MAX_FIELDS + 1);
  // Slot counter covers the longest common period, at most MAX_FIELDS squared.
  localparam int unsigned SLOT_W     = $clog2(MAX_FIELDS * MAX_FIELDS + 1);

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_NEVER   = 2'd0;
  localparam verdict_t VERDICT_ALWAYS  = 2'd1;
  localparam verdict_t VERDICT_RUNTIME = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Status of one field counter.
  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } fcnt_status_t;

endpackage : plcc_pkg
`default_nettype wire

@@ hdl/plcc_field_count.sv @@
// Field counter: finds the sentinel position of a layout word, one shift per cycle.
// Depends on plcc_pkg.
`default_nettype none
module plcc_field_count (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic [plcc_pkg::MAP_W-1:0]  word_i,
  output plcc_pkg::fcnt_status_t           status_o
);
  import plcc_pkg::*;

  logic [MAP_W-1:0] word_q, word_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done;

  // Done once only the sentinel (or nothing) is left.
  assign done = (word_q[MAP_W-1:1] == '0);

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      word_d = word_i;
      cnt_d  = '0;
    end else if (!done) begin
      word_d = {1'b0, word_q[MAP_W-1:1]};
      cnt_d  = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      cnt_q  <= '0;
    end else begin
      word_q <= word_d;
      cnt_q  <= cnt_d;
    end
  end

  assign status_o.done  = done;
  assign status_o.count = cnt_q;

endmodule : plcc_field_count
`default_nettype wire

@@ hdl/pointer_layout_compat_check_core.sv @@
// Top level of the pointer-layout compatibility checker: sequencer and slot walker.
// Depends on plcc_pkg and plcc_field_count.
//
//  channel | signals                             | dir | notes
//  --------+-------------------------------------+-----+---------------------------
//  in      | in_valid_i in_ready_o src/dst_map_i | in  | one layout pair per item
//  out     | out_valid_o out_ready_i verdict_o   | out | one verdict per item
//
// The count phase shifts both words one bit a cycle. The scan phase compares one
// slot pair a cycle through a single modular index pair, up to lcm(p,q) slots.
// Reset clears the sequencer and the output valid flag; there is no store.
// in_ready_o is high only in idle. A verdict waits in the output register, so the
// next item is taken while the last one is still unclaimed; a finished item
// waits in done if the output register is still full.
`default_nettype none
module pointer_layout_compat_check_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [plcc_pkg::MAP_W-1:0]  src_map_i,
  input  wire logic [plcc_pkg::MAP_W-1:0]  dst_map_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      plcc_pkg::verdict_t          verdict_o
);
  import plcc_pkg::*;

  state_e            state_q, state_d;
  logic [MAP_W-1:0]  src_q, src_d;
  logic [MAP_W-1:0]  dst_q, dst_d;
  logic [CNT_W-1:0]  a_q, a_d;     // source slot index, mod p
  logic [CNT_W-1:0]  b_q, b_d;     // destination slot index, mod q
  logic [SLOT_W-1:0] i_q, i_d;     // slots walked so far
  verdict_t          res_q, res_d; // verdict waiting for the output register
  logic              out_valid_q, out_valid_d;
  verdict_t          verdict_q, verdict_d;

  logic              accept;
  fcnt_status_t      src_st, dst_st;
  logic [CNT_W-1:0]  p, q, longer;
  logic [CNT_W-1:0]  a_inc, b_inc;
  logic              mismatch;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  plcc_field_count u_src_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .word_i   (src_map_i),
    .status_o (src_st)
  );

  plcc_field_count u_dst_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .word_i   (dst_map_i),
    .status_o (dst_st)
  );

  assign p      = src_st.count;
  assign q      = dst_st.count;
  assign longer = (p > q) ? p : q;

  // Next indexes wrap at the field counts, which gives the periodic view.
  assign a_inc    = (a_q + CNT_W'(1) == p) ? '0 : a_q + CNT_W'(1);
  assign b_inc    = (b_q + CNT_W'(1) == q) ? '0 : b_q + CNT_W'(1);
  assign mismatch = src_q[a_q] != dst_q[b_q];

  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    dst_d       = dst_q;
    a_d         = a_q;
    b_d         = b_q;
    i_d         = i_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          src_d   = src_map_i;
          dst_d   = dst_map_i;
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        a_d = '0;
        b_d = '0;
        i_d = '0;
        if (src_st.done && dst_st.done) begin
          if (src_q == dst_q) begin
            res_d   = VERDICT_ALWAYS;
            state_d = ST_DONE;
          end else if (src_q == '0 || dst_q == '0) begin
            res_d   = VERDICT_NEVER;
            state_d = ST_DONE;
          end else if (p == '0 || q == '0) begin
            // a word with only the sentinel has no fields
            res_d   = VERDICT_NEVER;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (mismatch) begin
          res_d   = (i_q < SLOT_W'(longer)) ? VERDICT_NEVER : VERDICT_RUNTIME;
          state_d = ST_DONE;
        end else if (a_inc == '0 && b_inc == '0) begin
          // both patterns wrapped together: full common period matched
          res_d   = VERDICT_ALWAYS;
          state_d = ST_DONE;
        end else begin
          a_d = a_inc;
          b_d = b_inc;
          i_d = i_q + SLOT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          verdict_d   = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q     <= src_d;
    dst_q     <= dst_d;
    a_q       <= a_d;
    b_q       <= b_d;
    i_q       <= i_d;
    res_q     <= res_d;
    verdict_q <= verdict_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

`ifndef ASSERT_OFF
  // Slot indexes stay inside their periods while scanning.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (a_q < p) && (b_q < q))
    else $error("slot index out of period");

  // The walk never runs past the common period bound.
  slot_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q < SLOT_W'(MAX_FIELDS * MAX_FIELDS)))
    else $error("slot counter overran");

  // An accepted item starts the count phase.
  accept_to_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_COUNT))
    else $error("accepted item did not start counting");

  // A verdict is only loaded from done, and never takes the unused code.
  verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o != 2'd3))
    else $error("illegal verdict code");

  // Leaving done always presents a verdict.
  done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && state_d == ST_IDLE) |=> out_valid_o)
    else $error("finished item lost its verdict");
`endif

endmodule : pointer_layout_compat_check_core
`default_nettype wire

@@ verif/tb_pointer_layout_compat_check_core.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for pointer_layout_compat_check_core: layout pairs in, verdicts out.
// Depends on plcc_pkg and the block's RTL.
module tb_pointer_layout_compat_check_core;
  import plcc_pkg::*;

  // Longest stretch with no item moving on either side before the run is called dead.
  // The slowest legal item walks lcm(63,62) slots plus counting, and the receiver
  // can also stall before it takes the verdict.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned RANDOM_PAIRS   = 121;

  typedef struct packed {
    logic [MAP_W-1:0] src;
    logic [MAP_W-1:0] dst;
  } layout_pair_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [MAP_W-1:0] src_map_i   = '0;
  logic [MAP_W-1:0] dst_map_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  verdict_t         verdict_o;

  // Pairs waiting to be driven, and verdicts owed by the block, oldest first.
  layout_pair_t layout_queue[$];
  verdict_t     verdict_queue[$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  // Sender burst shaping.
  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;
  layout_pair_t next_pair;

  // Receiver stall shaping: a 16-slot ready pattern, rotated, reshuffled each lap.
  logic [15:0] ready_pattern = 16'hFFFF;
  int unsigned ready_phase   = 0;

  pointer_layout_compat_check_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_map_i   (src_map_i),
    .dst_map_i   (dst_map_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Verdict predictor
  // ---------------------------------------------------------------------------

  // Slots below the sentinel: index of the highest set bit (0 for a word of 0 or 1).
  function automatic int unsigned slot_count(logic [MAP_W-1:0] w);
    int unsigned n;
    n = 0;
    for (int i = MAP_W - 1; i > 0; i--) begin
      if (w[i] && n == 0) n = i;
    end
    return n;
  endfunction

  // Walk both flag patterns as periodic sequences over their common period.
  // Mismatch inside the first max(p,q) slots means no size ever fits (never);
  // a later one means only some sizes fit (runtime check).
  function automatic verdict_t predict_verdict(logic [MAP_W-1:0] src, logic [MAP_W-1:0] dst);
    int unsigned p, q, g, r, t, period, longer, a, b;
    if (src == dst) return VERDICT_ALWAYS;
    if (src == '0 || dst == '0) return VERDICT_NEVER;
    p = slot_count(src);
    q = slot_count(dst);
    // a lone sentinel has no slots to compare
    if (p == 0 || q == 0) return VERDICT_NEVER;
    if (p > MAX_FIELDS || q > MAX_FIELDS) return VERDICT_RUNTIME;
    g = p;
    r = q;
    while (r != 0) begin
      t = g % r;
      g = r;
      r = t;
    end
    period = (p / g) * q;
    longer = (p > q) ? p : q;
    a = 0;
    b = 0;
    for (int unsigned i = 0; i < period; i++) begin
      if (src[a] != dst[b]) return (i < longer) ? VERDICT_NEVER : VERDICT_RUNTIME;
      a = (a + 1 == p) ? 0 : a + 1;
      b = (b + 1 == q) ? 0 : b + 1;
    end
    return VERDICT_ALWAYS;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [MAP_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // n flag slots (n <= 63) with the sentinel right above them.
  function automatic logic [MAP_W-1:0] layout_word(int unsigned n, logic [MAP_W-1:0] flags);
    logic [MAP_W-1:0] w;
    w    = flags & ((64'd1 << n) - 64'd1);
    w[n] = 1'b1;
    return w;
  endfunction

  // Repeat the low r bits of base across the whole word.
  function automatic logic [MAP_W-1:0] periodic_flags(int unsigned r, logic [MAP_W-1:0] base);
    logic [MAP_W-1:0] f;
    for (int unsigned i = 0; i < MAP_W; i++) f[i] = base[i % r];
    return f;
  endfunction

  task automatic add_pair(logic [MAP_W-1:0] src, logic [MAP_W-1:0] dst);
    layout_queue.push_back('{src: src, dst: dst});
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [MAP_W-1:0] s, d, base;
    int unsigned      kind, r, p, q, j;

    // Directed: degenerate words, widest layouts, and each decision branch.
    add_pair('0, '0);                                   // both empty
    add_pair(64'd1, 64'd1);                             // both bare sentinels
    add_pair('1, '1);                                   // identical, all set
    add_pair('0, rand_word() | 64'd1);                  // only source empty
    add_pair('1, '0);                                   // only destination empty
    add_pair(64'd1, 64'd5);                             // source has no slots
    add_pair(64'hA, 64'd1);                             // destination has no slots
    add_pair(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000); // 63 vs 62 zeros: full walk
    add_pair('1, 64'h7FFF_FFFF_FFFF_FFFF);              // 63 vs 62 ones: full walk
    add_pair(64'b101, 64'b1101);                        // mismatch past the longer period
    add_pair(64'b110, 64'b101);                         // mismatch at slot 0
    add_pair(64'b101, 64'b10101);                       // 2 vs 4 slots, same pattern
    add_pair(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
    add_pair('1, 64'hBFFF_FFFF_FFFF_FFFF);              // mismatch on the last slot
    add_pair(64'd2, 64'd3);                             // one slot each, flags differ
    add_pair(64'd3, 64'd7);                             // 1 vs 2 slots, all pointers
    s = rand_word();
    add_pair(s, s);
    add_pair(64'hFFFF_FFFF_FFFF_FFFE, 64'h5555_5555_5555_5555);
    add_pair(layout_word(63, periodic_flags(3, 64'b011)),
             layout_word(60, periodic_flags(3, 64'b011)));

    // Random: many layouts sharing a period, some with one flag flipped.
    repeat (RANDOM_PAIRS) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        r = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          p = r * $urandom_range(1, 63 / r);
          q = r * $urandom_range(1, 63 / r);
        end else begin
          p = r * $urandom_range(1, 24 / r);
          q = r * $urandom_range(1, 24 / r);
        end
        base = rand_word();
        s = layout_word(p, periodic_flags(r, base));
        d = layout_word(q, periodic_flags(r, base));
        case ($urandom_range(0, 3))
          0: begin
            j = $urandom_range(0, q - 1);
            d[j] = ~d[j];
          end
          1: begin
            j = $urandom_range(0, p - 1);
            s[j] = ~s[j];
          end
          default: ;
        endcase
      end else if (kind < 65) begin
        s = layout_word($urandom_range(1, 63), rand_word());
        d = layout_word($urandom_range(1, 63), rand_word());
      end else if (kind < 75) begin
        s = rand_word();
        d = rand_word();
      end else if (kind < 85) begin
        s = rand_word();
        d = rand_word();
        case ($urandom_range(0, 4))
          0: d = s;
          1: s = '0;
          2: d = '0;
          3: s = 64'd1;
          default: d = 64'd1;
        endcase
      end else begin
        p = $urandom_range(1, 63);
        s = layout_word(p, rand_word());
        d = layout_word(p, rand_word());
      end
      add_pair(s, d);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample at the falling edge so the queues are settled.
    while (layout_queue.size() != 0 || in_valid_i || verdict_queue.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of items separated by random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      // Item taken at this edge: owe its verdict.
      if (in_valid_i && in_ready_o)
        verdict_queue.push_back(predict_verdict(src_map_i, dst_map_i));
      // Valid is held until taken, so only touch the channel when it is free.
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (layout_queue.size() != 0) begin
          next_pair  = layout_queue.pop_front();
          in_valid_i <= 1'b1;
          src_map_i  <= next_pair.src;
          dst_map_i  <= next_pair.dst;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            // a quarter of bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stalls and verdict check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      ready_pattern <= 16'hFFFF;
      ready_phase   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_queue.size() == 0) begin
          $error("verdict: none expected, got %0d", verdict_o);
          error_count = error_count + 1;
        end else if (verdict_o !== verdict_queue[0]) begin
          $error("verdict: expected %0d, got %0d", verdict_queue[0], verdict_o);
          error_count = error_count + 1;
          void'(verdict_queue.pop_front());
        end else begin
          void'(verdict_queue.pop_front());
        end
      end
      out_ready_i <= ready_pattern[ready_phase];
      if (ready_phase == 15) begin
        ready_phase <= 0;
        // one lap in four never stalls; others keep at least one ready slot
        ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                     : 16'($urandom) | 16'h0001;
      end else begin
        ready_phase <= ready_phase + 1;
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
hdl/plcc_pkg.sv
hdl/plcc_field_count.sv
hdl/pointer_layout_compat_check_core.sv
verif/tb_pointer_layout_compat_check_core.sv
